[src/extended_gcd_coefficient_macros.svh]
// Assertion macros for the extended GCD coefficient block.
// Used by extended_gcd_coefficient.sv; expects clk and arst_n in scope.
`ifndef EXTENDED_GCD_COEFFICIENT_MACROS_SVH
`define EXTENDED_GCD_COEFFICIENT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ECG_ASSERT_SAME(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ECG_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

[src/ecg_pkg.sv]
// Package for the extended GCD coefficient block: width and word types.
// No dependencies; used by the stream interfaces and the top level.
`timescale 1ns / 1ps

package ecg_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	typedef logic [DATA_WIDTH-1:0]        data_t;
	typedef logic signed [DATA_WIDTH-1:0] sdata_t;
	typedef logic [CNT_W-1:0]             cnt_t;

endpackage

[src/ecg_if.sv]
// Valid/ready stream interfaces for operand and result words.
// Depends on ecg_pkg for the word types.
`timescale 1ns / 1ps

interface ecg_in_if;
	import ecg_pkg::*;

	logic   valid;
	logic   ready;
	sdata_t a_value;
	sdata_t b_value;

	modport source (output valid, output a_value, output b_value, input ready);
	modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

interface ecg_out_if;
	import ecg_pkg::*;

	logic   valid;
	logic   ready;
	data_t  gcd_value;
	sdata_t coef_x;

	modport source (output valid, output gcd_value, output coef_x, input ready);
	modport sink   (input valid, input gcd_value, input coef_x, output ready);
endinterface

[src/extended_gcd_coefficient.sv]
// Extended GCD coefficient block: top level, sequencer and shared datapath.
// Depends on ecg_pkg, ecg_if.sv and extended_gcd_coefficient_macros.svh.
`timescale 1ns / 1ps
//
// Usage
//   in_ch  : operand word {a_value, b_value}, signed, accepted when valid & ready.
//   out_ch : result word {gcd_value, coef_x}; gcd_value is the nonnegative gcd,
//            coef_x the coefficient of a with a*coef_x == gcd (mod b).
//   One operand word is worked on at a time; in_ch.ready is high only while
//   the sequencer is idle. The result sits in an output register, so a new
//   operand word can be taken while the previous result waits for out_ch.ready.
//   Each Euclid step runs a restoring divider, one quotient bit per cycle;
//   each divider cycle also folds its quotient bit into q*x1 (Horner form,
//   modulo 2^DATA_WIDTH). A check state before the divider and an update
//   state after it complete the step. Up to about 46 steps are needed for
//   32-bit operands.
//   If the output register still holds an unaccepted result when a result is
//   done, the block waits in its done state until it frees; no word is dropped.
//   Reset (arst_n low, asynchronous) returns to idle and clears out_ch.valid.
//
module extended_gcd_coefficient (
	input logic clk,
	input logic arst_n,
	ecg_in_if.sink    in_ch,
	ecg_out_if.source out_ch
);
	import ecg_pkg::*;

	`include "extended_gcd_coefficient_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPD,
		ST_DONE
	} state_t;

	state_t state_q;

	// remainders as magnitude plus sign; coefficients modulo 2^DATA_WIDTH
	data_t r0m_q, r1m_q;
	logic  r0n_q, r1n_q;
	data_t x0_q, x1_q;

	// divider: dividend shift register, partial remainder, q*x1 accumulator
	data_t n_q, rem_q, prod_q;
	cnt_t  cnt_q;

	logic   out_valid_q;
	data_t  gcd_q;
	sdata_t coef_q;

	logic [DATA_WIDTH:0] shifted, diff;
	logic                qbit;
	data_t               rem_d;
	data_t               prod_d;
	data_t               a_mag, b_mag;

	assign a_mag = in_ch.a_value[DATA_WIDTH-1] ? data_t'(-in_ch.a_value)
	                                           : data_t'(in_ch.a_value);
	assign b_mag = in_ch.b_value[DATA_WIDTH-1] ? data_t'(-in_ch.b_value)
	                                           : data_t'(in_ch.b_value);

	// one restoring divide step and one Horner step
	always_comb begin
		shifted = {rem_q, n_q[DATA_WIDTH-1]};
		diff    = shifted - {1'b0, r1m_q};
		qbit    = !diff[DATA_WIDTH];
		rem_d   = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
		prod_d  = {prod_q[DATA_WIDTH-2:0], 1'b0} + (qbit ? x1_q : '0);
	end

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign out_ch.valid     = out_valid_q;
	assign out_ch.gcd_value = gcd_q;
	assign out_ch.coef_x    = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			r0m_q       <= '0;
			r1m_q       <= '0;
			r0n_q       <= 1'b0;
			r1n_q       <= 1'b0;
			x0_q        <= '0;
			x1_q        <= '0;
			n_q         <= '0;
			rem_q       <= '0;
			prod_q      <= '0;
			cnt_q       <= '0;
			gcd_q       <= '0;
			coef_q      <= '0;
		end else begin
			// ST_DONE drives out_valid_q itself
			if (out_valid_q && out_ch.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						r0m_q   <= a_mag;
						r0n_q   <= in_ch.a_value[DATA_WIDTH-1];
						r1m_q   <= b_mag;
						r1n_q   <= in_ch.b_value[DATA_WIDTH-1];
						x0_q    <= data_t'(1);
						x1_q    <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (r1m_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						n_q     <= r0m_q;
						rem_q   <= '0;
						prod_q  <= '0;
						cnt_q   <= cnt_t'(DATA_WIDTH - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					n_q    <= {n_q[DATA_WIDTH-2:0], 1'b0};
					rem_q  <= rem_d;
					prod_q <= prod_d;
					cnt_q  <= cnt_q - cnt_t'(1);
					if (cnt_q == '0) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// truncated quotient has sign r0n ^ r1n; remainder keeps r0's sign
					r0m_q   <= r1m_q;
					r0n_q   <= r1n_q;
					r1m_q   <= rem_q;
					r1n_q   <= r0n_q;
					x0_q    <= x1_q;
					x1_q    <= (r0n_q == r1n_q) ? x0_q - prod_q : x0_q + prod_q;
					state_q <= ST_CHECK;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						gcd_q       <= r0m_q;
						coef_q      <= r0n_q ? sdata_t'(-x0_q) : sdata_t'(x0_q);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ECG_ASSERT_NEXT(a_accept_to_check, in_ch.valid && in_ch.ready, state_q == ST_CHECK, "accepted word did not start a step")
	`ECG_ASSERT_SAME(a_rem_below_div, state_q == ST_DIV, rem_q < r1m_q, "partial remainder not below divisor")
	`ECG_ASSERT_NEXT(a_rem_shrinks, state_q == ST_UPD, r1m_q < r0m_q, "remainder did not shrink")
	`ECG_ASSERT_NEXT(a_done_emits, state_q == ST_DONE && !out_valid_q, out_valid_q && state_q == ST_IDLE, "finished result not registered")

endmodule

[verif/testbench.sv]
// Self-checking testbench for extended_gcd_coefficient: gcd and Bezout coefficient of a.
// Depends on ecg_pkg, the ecg_in_if/ecg_out_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import ecg_pkg::*;

	// cycles without an accept on either channel before the run is declared hung
	localparam int HANG_LIMIT   = 12000;
	localparam int REPORT_LIMIT = 10;
	// cycles of tail after the last result
	localparam int TAIL_CYCLES  = 40;

	localparam sdata_t MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam sdata_t MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	// consecutive Fibonacci numbers: the longest remainder chain at 32 bits
	localparam sdata_t FIB_46   = 1836311903;
	localparam sdata_t FIB_45   = 1134903170;

	typedef struct {
		sdata_t a;
		sdata_t b;
		data_t  gcd;
		sdata_t coef;
	} gcd_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ecg_in_if  operand_ch ();
	ecg_out_if result_ch ();

	extended_gcd_coefficient i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (operand_ch),
		.out_ch (result_ch)
	);

	gcd_result_t pending_results[$];
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	bit          sender_idling   = 1'b0;
	bit          receiver_idling = 1'b0;
	int          stall_left      = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Extended Euclid, coefficient of a only. Quotients truncate toward zero,
	// which is what signed division on longint does. At 32 bits every
	// intermediate fits in 64 bits, so nothing wraps.
	function automatic gcd_result_t predict_gcd(input sdata_t a, input sdata_t b);
		gcd_result_t res;
		longint      rem_prev;
		longint      rem_cur;
		longint      rem_next;
		longint      x_prev;
		longint      x_cur;
		longint      x_next;
		longint      quot;
		rem_prev = longint'(a);
		rem_cur  = longint'(b);
		x_prev   = 1;
		x_cur    = 0;
		while (rem_cur != 0) begin
			quot     = rem_prev / rem_cur;
			rem_next = rem_prev - quot * rem_cur;
			x_next   = x_prev - quot * x_cur;
			rem_prev = rem_cur;
			rem_cur  = rem_next;
			x_prev   = x_cur;
			x_cur    = x_next;
		end
		// a negative last remainder flips both so the gcd comes out nonnegative;
		// gcd(MIN, 0) = 2^(W-1) only fits as an unsigned word
		if (rem_prev < 0) begin
			rem_prev = -rem_prev;
			x_prev   = -x_prev;
		end
		res.a    = a;
		res.b    = b;
		res.gcd  = data_t'(rem_prev);
		res.coef = sdata_t'(x_prev);
		return res;
	endfunction

	// Result receiver: random bursts of ready low while idling is on.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Result checker: every accepted word against the oldest prediction.
	always @(posedge clk) begin
		gcd_result_t exp_res;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: result word with nothing pending: gcd=%0d coef=%0d",
						$realtime, result_ch.gcd_value, result_ch.coef_x);
			end else begin
				exp_res = pending_results.pop_front();
				if (result_ch.gcd_value !== exp_res.gcd ||
						result_ch.coef_x !== exp_res.coef) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: a=%0d b=%0d expected gcd=%0d coef=%0d, got gcd=%0d coef=%0d",
							$realtime, exp_res.a, exp_res.b, exp_res.gcd, exp_res.coef,
							result_ch.gcd_value, result_ch.coef_x);
				end
			end
		end
	end

	// Hang detector: counts cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $realtime, HANG_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Sends one operand word; returns at the edge where it was accepted, with
	// valid still high so the next word can follow without a bubble.
	task automatic send_operands(input sdata_t a, input sdata_t b);
		int gap;
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			operand_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operand_ch.valid   <= 1'b1;
		operand_ch.a_value <= a;
		operand_ch.b_value <= b;
		do
			@(posedge clk);
		while (!operand_ch.ready);
		pending_results.insert(pending_results.size(), predict_gcd(a, b));
	endtask

	// Drops valid and holds off until every predicted result has come back.
	task automatic wait_for_results();
		operand_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Extremes of both operands, zero operands, sign combinations, MIN / -1.
	task automatic test_directed_cases();
		send_operands(0, 0);
		send_operands(5, 0);
		send_operands(-5, 0);
		send_operands(MOST_NEG, 0);
		send_operands(MOST_POS, 0);
		send_operands(0, 7);
		send_operands(0, -7);
		send_operands(0, MOST_NEG);
		send_operands(MOST_NEG, -1);
		send_operands(MOST_NEG, MOST_NEG);
		send_operands(MOST_POS, MOST_POS);
		send_operands(MOST_NEG, MOST_POS);
		send_operands(MOST_POS, MOST_NEG);
		send_operands(-1, -1);
		send_operands(1, -1);
		send_operands(12, 18);
		send_operands(-12, 18);
		send_operands(12, -18);
		send_operands(-12, -18);
		send_operands(240, 46);
		send_operands(MOST_POS, 2);
		send_operands(-1, MOST_NEG);
	endtask

	// Longest chains of Euclid steps, all four sign combinations.
	task automatic test_worst_case_chain();
		send_operands(FIB_46, FIB_45);
		send_operands(-FIB_46, FIB_45);
		send_operands(FIB_46, -FIB_45);
		send_operands(-FIB_45, -FIB_46);
	endtask

	// Mixed random operands: full range, small values, shared factors, zeros.
	task automatic test_random_operands(input int count);
		sdata_t a;
		sdata_t b;
		int     factor;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9)) inside
				[0:4]: begin
					a = sdata_t'($urandom);
					b = sdata_t'($urandom);
				end
				[5:6]: begin
					a = sdata_t'($urandom_range(0, 2000)) - 1000;
					b = sdata_t'($urandom_range(0, 2000)) - 1000;
				end
				[7:8]: begin
					// large common factor gives a gcd well above 1
					factor = $urandom_range(1, 65535);
					a = sdata_t'(factor * $urandom_range(0, 32767));
					b = sdata_t'(factor * $urandom_range(0, 32767));
					if ($urandom_range(0, 1)) a = -a;
					if ($urandom_range(0, 1)) b = -b;
				end
				default: begin
					a = $urandom_range(0, 1) ? sdata_t'($urandom) : MOST_NEG;
					b = $urandom_range(0, 1) ? sdata_t'(0) : sdata_t'($urandom_range(0, 2)) - 1;
					if ($urandom_range(0, 1)) begin
						b = a;
						a = sdata_t'($urandom_range(0, 2)) - 1;
					end
				end
			endcase
			send_operands(a, b);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		operand_ch.valid   <= 1'b0;
		operand_ch.a_value <= '0;
		operand_ch.b_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
		test_directed_cases();
		test_worst_case_chain();
		wait_for_results();
		test_random_operands(150);
		// hold the sender off until the block and the output register are empty
		wait_for_results();
		test_random_operands(150);

		// closing stretch without idling on either side
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		test_random_operands(70);
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
